// File: src/vcs_pkg.sv
// Shared types, constants and helpers for the velocity command shaper.
// No dependencies; used by vcs_lane and velocity_command_shaper.

package vcs_pkg;

  // fixed point format: signed Q5.10
  localparam int unsigned Q_SHIFT   = 10;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ALPHA_W   = 11;
  // serial multiplier: 16 multiplier bits, accumulator wide enough for a 17-bit multiplicand
  localparam int unsigned MUL_STEPS = 16;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned CNT_W     = $clog2(MUL_STEPS);

  localparam logic [ALPHA_W-1:0] Q_ONE = 11'd1024;

  // shaping thresholds in LSB
  localparam logic [16:0]        DEAD_BAND  = 17'd10;
  localparam logic [16:0]        MOVE_BAND  = 17'd1;
  localparam logic signed [15:0] SPIN_SPEED = 16'sd154;

  // configuration register indexes
  localparam logic [2:0] REG_FILTER_ALPHA   = 3'd0;
  localparam logic [2:0] REG_AXIS_GAINS     = 3'd1;
  localparam logic [2:0] REG_AXIS_MAX       = 3'd2;
  localparam logic [2:0] REG_AXIS_MIN       = 3'd3;
  localparam logic [2:0] REG_AXIS_SLEW      = 3'd4;
  localparam logic [2:0] REG_YAW_FF         = 3'd5;

  // configuration reset values
  localparam logic [10:0]        RST_FILTER_ALPHA = 11'd819;
  localparam logic [31:0]        RST_AXIS_GAINS   = 32'd26872320;
  localparam logic [31:0]        RST_AXIS_MAX     = 32'd53676032;
  localparam logic [31:0]        RST_AXIS_MIN     = 32'd6684979;
  localparam logic [31:0]        RST_AXIS_SLEW    = 32'd2031698;
  localparam logic signed [15:0] RST_YAW_FF       = 16'sd0;

  // input request
  typedef struct packed {
    logic              command;
    logic signed [15:0] linear_x;
    logic signed [15:0] angular_z;
  } vcs_in_t;

  // result request
  typedef struct packed {
    logic signed [15:0] setpoint_x;
    logic signed [15:0] setpoint_y;
  } vcs_out_t;

  // sequencer controls for one axis lane
  typedef struct packed {
    logic load;   // start low-pass multiply
    logic step;   // one multiplier bit
    logic mid;    // commit filter, start gain multiply
    logic fin;    // clamp and register scaled value
  } vcs_lane_ctrl_t;

  // saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: src/vcs_lane.sv
// One axis of the shaper: low-pass filter and gain scaling through a
// bit-serial shift-add multiplier, then clamp. Depends on vcs_pkg.

module vcs_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vcs_pkg::vcs_lane_ctrl_t ctrl,
  input  logic signed [15:0]     sample,
  input  logic [10:0]            alpha,
  input  logic [15:0]            gain,
  input  logic [15:0]            limit,
  output logic signed [15:0]     scaled
);

  localparam int unsigned AW = vcs_pkg::ACC_W;
  localparam int unsigned MW = vcs_pkg::MUL_STEPS;
  localparam int unsigned QW = AW + MW - vcs_pkg::Q_SHIFT;

  logic signed [AW-1:0] hi_r, hi_nxt, mcand_r, sum;
  logic [MW-1:0]        lo_r, lo_nxt;
  logic signed [15:0]   filt_r, scaled_r, filt_new, scaled_nxt;
  logic signed [QW-1:0] q, lim_pos, lim_neg, clamped;
  logic signed [AW-1:0] diff;

  // one multiplier bit: add multiplicand, shift pair right
  always_comb begin
    sum    = hi_r + (lo_r[0] ? mcand_r : '0);
    hi_nxt = {sum[AW-1], sum[AW-1:1]};
    lo_nxt = {sum[0], lo_r[MW-1:1]};
  end

  // product shifted down by the Q fraction (floor)
  assign q = {hi_r, lo_r[MW-1:vcs_pkg::Q_SHIFT]};

  // filter update: prev + floor(alpha * (sample - prev) / 1024)
  assign diff     = {{(AW-16){sample[15]}}, sample} - {{(AW-16){filt_r[15]}}, filt_r};
  assign filt_new = vcs_pkg::sat16({{(32-QW){q[QW-1]}}, q} +
                                   {{16{filt_r[15]}}, filt_r});

  // clamp scaled value to plus or minus the limit
  always_comb begin
    lim_pos = {{(QW-16){1'b0}}, limit};
    lim_neg = -lim_pos;
    if (q > lim_pos) begin
      clamped = lim_pos;
    end else if (q < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = q;
    end
    scaled_nxt = vcs_pkg::sat16({{(32-QW){clamped[QW-1]}}, clamped});
  end

  // filter state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      scaled_r <= '0;
    end else begin
      if (ctrl.mid) filt_r <= filt_new;
      if (ctrl.fin) scaled_r <= scaled_nxt;
    end
  end

  // multiplier datapath
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi_r    <= '0;
      lo_r    <= {{(MW-11){1'b0}}, alpha};
      mcand_r <= diff;
    end else if (ctrl.mid) begin
      hi_r    <= '0;
      lo_r    <= gain;
      mcand_r <= {{(AW-16){filt_new[15]}}, filt_new};
    end else if (ctrl.step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign scaled = scaled_r;

endmodule

// File: src/velocity_command_shaper.sv
// Top level of the two-axis velocity command shaper.
// Depends on vcs_pkg and vcs_lane.

// A velocity request (command 0) keeps the block busy: each axis runs two
// 16-step bit-serial multiplies (low-pass weight, then gain) in its own lane,
// both lanes side by side, with loading at acceptance, filter commit between
// the multiplies, then clamp and target shaping. A tick request (command 1) is
// taken when idle and its setpoints appear in the output register on the next
// cycle; a tick waits while a velocity request runs or an earlier result is
// still held and not taken. Velocity requests produce no result. Configuration
// writes are always ready and must be issued only while the block is idle.

module velocity_command_shaper (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vcs_pkg::vcs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vcs_pkg::vcs_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MID  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_POST = 3'd5;

  localparam int unsigned CW = vcs_pkg::CNT_W;
  localparam logic [CW-1:0] STEP_LAST = CW'(vcs_pkg::MUL_STEPS - 1);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [10:0]        alpha_r;
  logic [31:0]        gains_r, max_r, min_r, slew_r;
  logic signed [15:0] ff_r;

  logic signed [15:0] tgt_x_r, tgt_y_r, out_x_r, out_y_r;
  logic               out_valid_r;

  logic               in_acc, vel_acc, tick_acc;
  logic [10:0]        alpha_eff;
  logic signed [15:0] neg_z, rx, ry;
  logic signed [15:0] spin_x, tx_nxt, ty_min, ty_nxt;
  vcs_pkg::vcs_lane_ctrl_t ctrl;

  // absolute value, one bit wider
  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return e[16] ? 17'(-e) : 17'(e);
  endfunction

  // dead band and minimum starting speed
  function automatic logic signed [15:0] min_start(input logic signed [15:0] v,
                                                   input logic [15:0] minv);
    logic [16:0]        m;
    logic signed [31:0] mv;
    logic signed [15:0] r;
    m  = abs17(v);
    mv = {16'd0, minv};
    if (m < vcs_pkg::DEAD_BAND) begin
      r = '0;
    end else if (m < {1'b0, minv}) begin
      r = (v > 16'sd0) ? vcs_pkg::sat16(mv) : vcs_pkg::sat16(-mv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // move current toward target by at most step
  function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] tgt,
                                              input logic [15:0] step);
    logic signed [17:0] c, t, s, n;
    c = {{2{cur[15]}}, cur};
    t = {{2{tgt[15]}}, tgt};
    s = {2'b00, step};
    if (c < t) begin
      n = c + s;
      if (n > t) n = t;
    end else if (c > t) begin
      n = c - s;
      if (n < t) n = t;
    end else begin
      n = c;
    end
    return n[15:0];
  endfunction

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE) &&
                     (!in_data.command || !out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign vel_acc   = in_acc && !in_data.command;
  assign tick_acc  = in_acc && in_data.command;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= vcs_pkg::RST_FILTER_ALPHA;
      gains_r <= vcs_pkg::RST_AXIS_GAINS;
      max_r   <= vcs_pkg::RST_AXIS_MAX;
      min_r   <= vcs_pkg::RST_AXIS_MIN;
      slew_r  <= vcs_pkg::RST_AXIS_SLEW;
      ff_r    <= vcs_pkg::RST_YAW_FF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcs_pkg::REG_FILTER_ALPHA: alpha_r <= cfg_data[10:0];
        vcs_pkg::REG_AXIS_GAINS:   gains_r <= cfg_data;
        vcs_pkg::REG_AXIS_MAX:     max_r   <= cfg_data;
        vcs_pkg::REG_AXIS_MIN:     min_r   <= cfg_data;
        vcs_pkg::REG_AXIS_SLEW:    slew_r  <= cfg_data;
        vcs_pkg::REG_YAW_FF:       ff_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input conditioning
  assign alpha_eff = (alpha_r > vcs_pkg::Q_ONE) ? vcs_pkg::Q_ONE : alpha_r;
  assign neg_z     = (in_data.angular_z == 16'sh8000) ? 16'sh7fff : -in_data.angular_z;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (vel_acc) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) state_nxt = ST_MID;
      end
      ST_MID: begin
        cnt_nxt   = '0;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_POST;
      ST_POST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign ctrl.load = vel_acc;
  assign ctrl.step = (state_r == ST_MUL1) || (state_r == ST_MUL2);
  assign ctrl.mid  = (state_r == ST_MID);
  assign ctrl.fin  = (state_r == ST_FIN);

  // axis lanes
  vcs_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_data.linear_x),
    .alpha  (alpha_eff),
    .gain   (gains_r[15:0]),
    .limit  (max_r[15:0]),
    .scaled (rx)
  );

  vcs_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (neg_z),
    .alpha  (alpha_eff),
    .gain   (gains_r[31:16]),
    .limit  (max_r[31:16]),
    .scaled (ry)
  );

  // spin protection, minimum speed, yaw feedforward
  always_comb begin
    spin_x = ((abs17(ry) > vcs_pkg::DEAD_BAND) && (abs17(rx) < vcs_pkg::DEAD_BAND)) ?
             vcs_pkg::SPIN_SPEED : rx;
    tx_nxt = min_start(spin_x, min_r[15:0]);
    ty_min = min_start(ry, min_r[31:16]);
    if ((abs17(tx_nxt) > vcs_pkg::MOVE_BAND) || (abs17(ty_min) > vcs_pkg::MOVE_BAND)) begin
      ty_nxt = vcs_pkg::sat16({{16{ty_min[15]}}, ty_min} + {{16{ff_r[15]}}, ff_r});
    end else begin
      ty_nxt = ty_min;
    end
  end

  // targets, slewed outputs and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_POST) begin
        tgt_x_r <= tx_nxt;
        tgt_y_r <= ty_nxt;
      end
      if (tick_acc) begin
        out_x_r     <= slew(out_x_r, tgt_x_r, slew_r[15:0]);
        out_y_r     <= slew(out_y_r, tgt_y_r, slew_r[31:16]);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.setpoint_x = out_x_r;
  assign out_data.setpoint_y = out_y_r;

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request accepted while shaping is in progress");

  a_vel_starts: assert property (@(posedge clk) disable iff (!rst_n)
    vel_acc |=> (state_r == ST_MUL1) && (cnt_r == '0))
    else $error("velocity request did not start the multiply sequence");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> out_valid_r)
    else $error("tick request produced no result");

  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tick_acc))
    else $error("result appeared without a tick request");

  a_targets_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && !$past(state_r == ST_POST) |-> $stable(tgt_x_r) && $stable(tgt_y_r))
    else $error("targets changed outside target shaping");

endmodule

// File: test/vcs_checker.sv
`timescale 1ns / 1ps
// Scoreboard for velocity_command_shaper: tracks register writes, predicts setpoints
// for every accepted tick and compares them with the result channel. Depends on vcs_pkg.

module vcs_checker
  import vcs_pkg::*;
#(
  parameter logic TICK_CODE = 1'b1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  vcs_in_t   in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  vcs_out_t  out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int        mismatches,
  output int        pending
);

  localparam longint DEAD = DEAD_BAND;
  localparam longint MOVING = MOVE_BAND;
  localparam longint UNITY = Q_ONE;

  // register shadow
  logic [10:0]        alpha;
  logic [31:0]        gains;
  logic [31:0]        max_speeds;
  logic [31:0]        min_speeds;
  logic [31:0]        slew_steps;
  logic signed [15:0] yaw_ff;

  // shaper state
  logic signed [15:0] filt_x, filt_y;
  logic signed [15:0] tgt_x, tgt_y;
  logic signed [15:0] set_x, set_y;

  vcs_out_t setpoint_q[$];

  function automatic logic signed [15:0] clip16(input longint v);
    logic [63:0] bits;
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    bits = v;
    return bits[15:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // first-order low-pass, floor of the weighted sum
  function automatic logic signed [15:0] lowpass(input longint prev, input longint sample);
    longint a;
    a = alpha;
    if (a > UNITY) a = UNITY;
    return clip16((a * sample + (UNITY - a) * prev) >>> Q_SHIFT);
  endfunction

  // gain then symmetric clamp
  function automatic longint scale_limit(input longint f, input longint gain, input longint lim);
    longint s;
    s = (f * gain) >>> Q_SHIFT;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return clip16(s);
  endfunction

  // dead band and minimum starting speed
  function automatic logic signed [15:0] start_speed(input longint v, input longint minv);
    if (mag(v) < DEAD) return '0;
    if (mag(v) < minv) return clip16((v > 0) ? minv : -minv);
    return clip16(v);
  endfunction

  function automatic logic signed [15:0] slew_toward(input longint cur, input longint tgt,
                                                     input longint step);
    longint n;
    if (cur < tgt) begin
      n = cur + step;
      return clip16((n > tgt) ? tgt : n);
    end
    if (cur > tgt) begin
      n = cur - step;
      return clip16((n < tgt) ? tgt : n);
    end
    return clip16(cur);
  endfunction

  always @(posedge clk) begin
    longint az, rx, ry;
    vcs_out_t want;
    if (!rst_n) begin
      alpha = RST_FILTER_ALPHA;
      gains = RST_AXIS_GAINS;
      max_speeds = RST_AXIS_MAX;
      min_speeds = RST_AXIS_MIN;
      slew_steps = RST_AXIS_SLEW;
      yaw_ff = RST_YAW_FF;
      filt_x = '0;
      filt_y = '0;
      tgt_x = '0;
      tgt_y = '0;
      set_x = '0;
      set_y = '0;
      setpoint_q.delete();
      mismatches = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_ALPHA: alpha = cfg_data[10:0];
          REG_AXIS_GAINS:   gains = cfg_data;
          REG_AXIS_MAX:     max_speeds = cfg_data;
          REG_AXIS_MIN:     min_speeds = cfg_data;
          REG_AXIS_SLEW:    slew_steps = cfg_data;
          REG_YAW_FF:       yaw_ff = cfg_data[15:0];
          default: ;
        endcase
      end

      // compare a delivered setpoint with the oldest prediction
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          $display("%0t unexpected setpoint: expected none, got x %0d y %0d", $time,
                   out_data.setpoint_x, out_data.setpoint_y);
          mismatches++;
        end else begin
          want = setpoint_q.pop_front();
          if (out_data.setpoint_x !== want.setpoint_x) begin
            $display("%0t setpoint_x mismatch: expected %0d, got %0d", $time,
                     want.setpoint_x, out_data.setpoint_x);
            mismatches++;
          end
          if (out_data.setpoint_y !== want.setpoint_y) begin
            $display("%0t setpoint_y mismatch: expected %0d, got %0d", $time,
                     want.setpoint_y, out_data.setpoint_y);
            mismatches++;
          end
        end
      end

      // predict from an accepted request
      if (in_valid && in_ready) begin
        if (in_data.command == TICK_CODE) begin
          set_x = slew_toward(set_x, tgt_x, slew_steps[15:0]);
          set_y = slew_toward(set_y, tgt_y, slew_steps[31:16]);
          want.setpoint_x = set_x;
          want.setpoint_y = set_y;
          setpoint_q.push_back(want);
        end else begin
          az = in_data.angular_z;
          filt_x = lowpass(filt_x, in_data.linear_x);
          filt_y = lowpass(filt_y, clip16(-az));
          rx = scale_limit(filt_x, gains[15:0], max_speeds[15:0]);
          ry = scale_limit(filt_y, gains[31:16], max_speeds[31:16]);
          // spin protection: turning on the spot gets a small forward push
          if (mag(ry) > DEAD && mag(rx) < DEAD) rx = SPIN_SPEED;
          tgt_x = start_speed(rx, min_speeds[15:0]);
          tgt_y = start_speed(ry, min_speeds[31:16]);
          // feedforward only while moving
          if (mag(tgt_x) > MOVING || mag(tgt_y) > MOVING)
            tgt_y = clip16(longint'(tgt_y) + longint'(yaw_ff));
        end
      end
    end
    pending <= setpoint_q.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the velocity_command_shaper testbench: clock, reset, request and register
// stimulus, result back-pressure and verdict. Depends on vcs_pkg and vcs_checker.

module tb_top;
  import vcs_pkg::*;

  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam int   SETTLE_CYCLES = 50;

  typedef enum int {CFG_RESET, CFG_ALL_ONES, CFG_ALL_ZERO, CFG_RANDOM, CFG_CORNER} cfg_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  vcs_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  vcs_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          pending;
  int          in_calm;

  always #2 clk = ~clk;

  velocity_command_shaper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vcs_checker #(.TICK_CODE(CMD_TICK)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // one request with a random lead-in gap, held until accepted
  task automatic send_request(input logic cmd, input logic signed [15:0] lx,
                              input logic signed [15:0] az);
    int gap;
    vcs_in_t req;
    if (in_calm > 0) begin
      gap = 0;
      in_calm--;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 15) == 0) in_calm = $urandom_range(10, 40);
    end
    req.command = cmd;
    req.linear_x = lx;
    req.angular_z = az;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // speed value biased toward extremes, dead band and minimum speeds
  function automatic logic signed [15:0] pick_speed();
    logic [31:0] r;
    int v;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return r[15:0];
      1: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      2: v = $urandom_range(0, 40);
      3: v = $urandom_range(0, 400);
      default: v = $urandom_range(0, 4096);
    endcase
    if (r[16]) v = -v;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_half(input int lo, input int hi);
    logic [31:0] r;
    case ($urandom_range(0, 5))
      0: r = 32'h0000;
      1: r = 32'hffff;
      2: r = $urandom;
      default: r = $urandom_range(lo, hi);
    endcase
    return r[15:0];
  endfunction

  task automatic random_request();
    logic cmd;
    cmd = ($urandom_range(0, 99) < 45) ? CMD_TICK : CMD_VELOCITY;
    send_request(cmd, pick_speed(), pick_speed());
  endtask

  // stop offering requests and wait for the block to drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write every register for one setting
  task automatic apply_config(input cfg_mode_e mode);
    logic [31:0] w [6];
    logic [31:0] r;
    case (mode)
      CFG_RESET: begin
        w[REG_FILTER_ALPHA] = {21'd0, RST_FILTER_ALPHA};
        w[REG_AXIS_GAINS] = RST_AXIS_GAINS;
        w[REG_AXIS_MAX] = RST_AXIS_MAX;
        w[REG_AXIS_MIN] = RST_AXIS_MIN;
        w[REG_AXIS_SLEW] = RST_AXIS_SLEW;
        w[REG_YAW_FF] = {{16{RST_YAW_FF[15]}}, RST_YAW_FF};
      end
      CFG_ALL_ONES: begin
        for (int i = 0; i < 6; i++) w[i] = 32'hffff_ffff;
        w[REG_YAW_FF] = 32'h0000_7fff;
      end
      CFG_ALL_ZERO: begin
        for (int i = 0; i < 6; i++) w[i] = 32'h0;
        w[REG_YAW_FF] = 32'hffff_8000;
      end
      CFG_CORNER: begin
        // alpha above one, limits beyond the field range, x slew frozen
        w[REG_FILTER_ALPHA] = 32'h0000_07ff;
        w[REG_AXIS_GAINS] = 32'h0400_0c00;
        w[REG_AXIS_MAX] = 32'hffff_ffff;
        w[REG_AXIS_MIN] = 32'h0040_0040;
        w[REG_AXIS_SLEW] = 32'h0100_0000;
        w[REG_YAW_FF] = 32'h0000_7fff;
      end
      default: begin
        r = $urandom;
        case ($urandom_range(0, 4))
          0: r[10:0] = 11'd0;
          1: r[10:0] = Q_ONE;
          2: r[10:0] = 11'h7ff;
          3: r[10:0] = 11'($urandom_range(0, 2047));
          default: r[10:0] = 11'($urandom_range(500, 1024));
        endcase
        w[REG_FILTER_ALPHA] = r;
        w[REG_AXIS_GAINS] = {pick_half(256, 4096), pick_half(256, 4096)};
        w[REG_AXIS_MAX] = {pick_half(200, 3000), pick_half(200, 3000)};
        w[REG_AXIS_MIN] = {pick_half(0, 600), pick_half(0, 600)};
        w[REG_AXIS_SLEW] = {pick_half(1, 200), pick_half(1, 200)};
        r = $urandom;
        if ($urandom_range(0, 2) != 0) r[15:0] = pick_speed() >>> 4;
        w[REG_YAW_FF] = r;
      end
    endcase
    for (int i = 0; i < 6; i++) write_reg(i[2:0], w[i]);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, calm stretches and two long hold-offs
  initial begin : receiver
    int stall;
    int taken;
    int calm;
    taken = 0;
    calm = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 40 || taken == 350) begin
        stall = 600;
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 17);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // requests, register settings and verdict
  initial begin : stimulus
    cfg_mode_e mode;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_calm = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, saturating negation, dead band, spin, minimum speed
    apply_config(CFG_RESET);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sh7fff, 16'sh8000);
    send_request(CMD_TICK, 16'sh8000, 16'sh7fff);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sh8000, 16'sh7fff);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sd5, -16'sd3000);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sd3, 16'sd2);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, -16'sd40, 16'sd0);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    settle();

    // directed: alpha above one, wide limits, frozen x slew, full feedforward
    apply_config(CFG_CORNER);
    send_request(CMD_VELOCITY, 16'sh7fff, 16'sd0);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sd100, -16'sd100);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sh8000, 16'sh8000);
    send_request(CMD_TICK, 16'sd0, 16'sd0);
    send_request(CMD_VELOCITY, 16'sd0, 16'sd0);
    send_request(CMD_TICK, 16'sh7fff, 16'sh7fff);

    // random phases, each under its own setting
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        1: mode = CFG_ALL_ONES;
        4: mode = CFG_ALL_ZERO;
        7: mode = CFG_RESET;
        default: mode = CFG_RANDOM;
      endcase
      apply_config(mode);
      repeat (150) random_request();
    end
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
